// File: rtl/core/bht_pkg.sv
// ----------------------------------------------------------------------------
// bht_pkg
// Shared types, reset constants and ranking function for the ball tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package bht_pkg;

    localparam logic [15:0] DECAY_RST  = 16'd13521;
    localparam logic [14:0] RADIUS_RST = 15'd686;
    localparam logic [15:0] THR_RST    = 16'd1311;

    localparam logic [1:0] CFG_DECAY  = 2'd0;
    localparam logic [1:0] CFG_RADIUS = 2'd1;
    localparam logic [1:0] CFG_THR    = 2'd2;

    typedef struct packed {
        logic        seen;
        logic [15:0] x;
        logic [15:0] y;
    } t_frame;

    typedef struct packed {
        logic [15:0] decay;
        logic [14:0] radius;
        logic [15:0] thr;
    } t_cfg;

    function automatic logic rank_above(
        input logic [15:0] ca, input logic [15:0] xa, input logic [15:0] ya,
        input logic [15:0] cb, input logic [15:0] xb, input logic [15:0] yb);
        logic r;
        if (ca != cb) begin
            r = ca > cb;
        end else if (xa != xb) begin
            r = $signed(xa) > $signed(xb);
        end else begin
            r = $signed(ya) > $signed(yb);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/bht_if.sv
// ----------------------------------------------------------------------------
// bht_if
// Valid/ready channels: detections in, estimates out, register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface bht_obs_if;
    logic        valid;
    logic        ready;
    logic        obs_present;
    logic [15:0] obs_confidence;
    logic [15:0] obs_x;
    logic [15:0] obs_y;
    logic        frame_last;
    modport source (output valid, obs_present, obs_confidence, obs_x, obs_y, frame_last,
                    input ready);
    modport sink   (input valid, obs_present, obs_confidence, obs_x, obs_y, frame_last,
                    output ready);
endinterface

interface bht_est_if;
    logic        valid;
    logic        ready;
    logic [15:0] est_x;
    logic [15:0] est_y;
    logic [15:0] est_certainty;
    logic        table_overflow;
    modport source (output valid, est_x, est_y, est_certainty, table_overflow, input ready);
    modport sink   (input valid, est_x, est_y, est_certainty, table_overflow, output ready);
endinterface

interface bht_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bht_ram.sv
// ----------------------------------------------------------------------------
// bht_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module bht_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/bht_front.sv
// ----------------------------------------------------------------------------
// bht_front
// Keeps the best detection of a frame, emits one frame word at frame end.
// ----------------------------------------------------------------------------
`default_nettype none
module bht_front (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bht_obs_if.sink     i_obs,
    input  wire logic   i_full,
    output logic        o_push,
    output bht_pkg::t_frame o_frame
);
    logic        r_seen;
    logic [15:0] r_conf, r_x, r_y;
    logic        acc, take;

    assign i_obs.ready = !i_full;
    assign acc  = i_obs.valid && i_obs.ready;
    assign take = i_obs.obs_present && (!r_seen ||
                  bht_pkg::rank_above(i_obs.obs_confidence, i_obs.obs_x, i_obs.obs_y,
                                      r_conf, r_x, r_y));

    assign o_push       = acc && i_obs.frame_last;
    assign o_frame.seen = r_seen || take;
    assign o_frame.x    = take ? i_obs.obs_x : r_x;
    assign o_frame.y    = take ? i_obs.obs_y : r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_conf <= '0;
            r_x    <= '0;
            r_y    <= '0;
        end else if (acc) begin
            if (i_obs.frame_last) begin
                r_seen <= 1'b0;
                r_conf <= '0;
                r_x    <= '0;
                r_y    <= '0;
            end else if (take) begin
                r_seen <= 1'b1;
                r_conf <= i_obs.obs_confidence;
                r_x    <= i_obs.obs_x;
                r_y    <= i_obs.obs_y;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/bht_fifo.sv
// ----------------------------------------------------------------------------
// bht_fifo
// Two-word queue of frame words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module bht_fifo (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire bht_pkg::t_frame i_frame,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_valid,
    output bht_pkg::t_frame o_frame
);
    bht_pkg::t_frame r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_frame = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_frame;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/bht_back.sv
// ----------------------------------------------------------------------------
// bht_back
// Frame-end engine: merge/decay/drop walk, placement if a ball was seen, report walk.
// ----------------------------------------------------------------------------
`default_nettype none
module bht_back #(
    parameter int MAX_CIRCLES = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire bht_pkg::t_cfg   i_cfg,
    input  wire logic   i_fvalid,
    input  wire bht_pkg::t_frame i_frame,
    output logic        o_pop,
    bht_est_if.source   o_est
);
    localparam int IW = $clog2(MAX_CIRCLES);
    localparam logic [IW-1:0] LAST = IW'(MAX_CIRCLES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MRD, S_MLAT, S_MMUL, S_MWB, S_PLACE, S_RRD, S_RCMP, S_OUT
    } t_state;

    t_state r_state;
    logic [IW-1:0] r_idx;
    logic [MAX_CIRCLES-1:0] r_valid;
    logic        r_fresh;
    logic        r_seen;
    logic [15:0] r_bx, r_by;
    logic [16:0] r_miss, r_keep;
    logic [29:0] r_r2;
    logic [47:0] r_ent;
    logic [32:0] r_dx2, r_dy2;
    logic [33:0] r_prod;
    logic        r_near;
    logic        r_free_f, r_weak_f, r_pick_f, r_ovf;
    logic [IW-1:0] r_free, r_weak;
    logic [15:0] r_weak_c;
    logic [47:0] r_pick;

    logic        we;
    logic [IW-1:0] waddr;
    logic [47:0] wdata, ram_q, rd;
    logic signed [16:0] dx, dy;
    logic signed [33:0] dx2, dy2;
    logic        near;
    logic [16:0] ma, mb, newdiff;
    logic [15:0] newc, decc;
    logic [IW-1:0] slot;

    bht_ram #(.WIDTH(48), .DEPTH(MAX_CIRCLES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_q)
    );

    assign rd  = (r_fresh && r_idx == '0) ? {32'd0, bht_pkg::THR_RST} : ram_q;
    assign dx  = $signed({r_bx[15], r_bx}) - $signed({rd[47], rd[47:32]});
    assign dy  = $signed({r_by[15], r_by}) - $signed({rd[31], rd[31:16]});
    assign dx2 = dx * dx;
    assign dy2 = dy * dy;
    assign near = r_seen && ({1'b0, r_dx2} + {1'b0, r_dy2} < {4'd0, r_r2});
    assign ma   = near ? r_miss : {1'b0, r_ent[15:0]};
    assign mb   = near ? (17'h10000 - {1'b0, r_ent[15:0]}) : r_keep;
    assign decc = r_prod[31:16];
    assign newdiff = 17'h10000 - r_miss;
    assign newc = newdiff[16] ? 16'hFFFF : newdiff[15:0];
    assign slot = r_free_f ? r_free : r_weak;

    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = {r_ent[47:16], decc};
        if (r_state == S_MWB && !r_near) begin
            we = 1'b1;
        end else if (r_state == S_PLACE) begin
            we    = 1'b1;
            waddr = slot;
            wdata = {r_bx, r_by, newc};
        end
    end

    assign o_pop = r_state == S_IDLE && i_fvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_valid   <= MAX_CIRCLES'(1);
            r_fresh   <= 1'b1;
            o_est.valid <= 1'b0;
        end else begin
            if (o_est.valid && o_est.ready && r_state != S_OUT) begin
                o_est.valid <= 1'b0;
            end
            if (we && waddr == '0) begin
                r_fresh <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_fvalid) begin
                        r_seen   <= i_frame.seen;
                        r_bx     <= i_frame.x;
                        r_by     <= i_frame.y;
                        r_miss   <= 17'h10000 - {1'b0, i_cfg.decay};
                        r_keep   <= 17'h10000 - {1'b0, i_cfg.decay};
                        r_r2     <= i_cfg.radius * i_cfg.radius;
                        r_free_f <= 1'b0;
                        r_weak_f <= 1'b0;
                        r_ovf    <= 1'b0;
                        r_idx    <= '0;
                        r_state  <= S_MRD;
                    end
                end
                S_MRD: begin
                    if (r_valid[r_idx]) begin
                        r_state <= S_MLAT;
                    end else begin
                        if (!r_free_f) begin
                            r_free_f <= 1'b1;
                            r_free   <= r_idx;
                        end
                        if (r_idx == LAST) begin
                            r_idx    <= '0;
                            r_pick_f <= 1'b0;
                            r_state  <= r_seen ? S_PLACE : S_RRD;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_MLAT: begin
                    r_ent   <= rd;
                    r_dx2   <= dx2[32:0];
                    r_dy2   <= dy2[32:0];
                    r_state <= S_MMUL;
                end
                S_MMUL: begin
                    r_near  <= near;
                    r_prod  <= ma * mb;
                    r_state <= S_MWB;
                end
                S_MWB: begin
                    if (r_near) begin
                        r_miss <= r_prod[32:16];
                        r_valid[r_idx] <= 1'b0;
                        if (!r_free_f) begin
                            r_free_f <= 1'b1;
                            r_free   <= r_idx;
                        end
                    end else if (r_seen && decc < i_cfg.thr) begin
                        r_valid[r_idx] <= 1'b0;
                        if (!r_free_f) begin
                            r_free_f <= 1'b1;
                            r_free   <= r_idx;
                        end
                    end else if (!r_weak_f || decc < r_weak_c) begin
                        r_weak_f <= 1'b1;
                        r_weak   <= r_idx;
                        r_weak_c <= decc;
                    end
                    if (r_idx == LAST) begin
                        r_idx    <= '0;
                        r_pick_f <= 1'b0;
                        r_state  <= r_seen ? S_PLACE : S_RRD;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_MRD;
                    end
                end
                S_PLACE: begin
                    r_valid[slot] <= 1'b1;
                    r_ovf   <= !r_free_f;
                    r_state <= S_RRD;
                end
                S_RRD: begin
                    if (r_valid[r_idx]) begin
                        r_state <= S_RCMP;
                    end else if (r_idx == LAST) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_RCMP: begin
                    if (!r_pick_f || bht_pkg::rank_above(rd[15:0], rd[47:32], rd[31:16],
                            r_pick[15:0], r_pick[47:32], r_pick[31:16])) begin
                        r_pick_f <= 1'b1;
                        r_pick   <= rd;
                    end
                    if (r_idx == LAST) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RRD;
                    end
                end
                S_OUT: begin
                    if (!o_est.valid || o_est.ready) begin
                        o_est.valid          <= 1'b1;
                        o_est.est_x          <= r_pick_f ? r_pick[47:32] : 16'd0;
                        o_est.est_y          <= r_pick_f ? r_pick[31:16] : 16'd0;
                        o_est.est_certainty  <= r_pick_f ? r_pick[15:0] : 16'd0;
                        o_est.table_overflow <= r_ovf;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/ball_hypothesis_tracker_top.sv
// Flow: a frame end passes through the queue; the back engine then runs the
//   merge/decay/drop walk over every slot, the placement and the report walk,
//   and then presents the estimate on the output.
// Throughput: non-final words 1 per cycle while the queue has room; frame ends
//   are bounded by the back engine's two table walks, up to two words queued.
// Reset: synchronous active low; table holds one circle at the origin.
// ----------------------------------------------------------------------------
// ball_hypothesis_tracker_top
// Ball tracker: front keeps best detection, back updates circle table.
// ----------------------------------------------------------------------------
`default_nettype none
module ball_hypothesis_tracker_top #(
    parameter int MAX_CIRCLES = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bht_obs_if.sink   i_obs,
    bht_cfg_if.sink   i_cfg,
    bht_est_if.source o_est
);
    bht_pkg::t_cfg   r_cfg;
    bht_pkg::t_frame push_frame, pop_frame;
    logic push, pop, full, fvalid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decay  <= bht_pkg::DECAY_RST;
            r_cfg.radius <= bht_pkg::RADIUS_RST;
            r_cfg.thr    <= bht_pkg::THR_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bht_pkg::CFG_DECAY:  r_cfg.decay  <= i_cfg.data;
                bht_pkg::CFG_RADIUS: r_cfg.radius <= i_cfg.data[14:0];
                bht_pkg::CFG_THR:    r_cfg.thr    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    bht_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_obs   (i_obs),
        .i_full  (full),
        .o_push  (push),
        .o_frame (push_frame)
    );

    bht_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (fvalid),
        .o_frame (pop_frame)
    );

    bht_back #(.MAX_CIRCLES(MAX_CIRCLES)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_fvalid (fvalid),
        .i_frame  (pop_frame),
        .o_pop    (pop),
        .o_est    (o_est)
    );
endmodule
`default_nettype wire

// File: rtl/core/bht_checker.sv
// ----------------------------------------------------------------------------
// bht_checker
// Port-level checks: output hold, reset, frame/estimate accounting.
// ----------------------------------------------------------------------------
`default_nettype none
module bht_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_in_last,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic [15:0] i_out_cert
);
    logic [3:0] r_pend;
    logic in_fr, out_acc;

    assign in_fr   = i_in_valid && i_in_ready && i_in_last;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 4'd0;
        end else begin
            r_pend <= r_pend + {3'd0, in_fr} - {3'd0, out_acc};
        end
    end

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("estimate valid after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_cert))
        else $error("estimate dropped while stalled");
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_pend != 4'd0)
        else $error("estimate without frame end");
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 4'd4)
        else $error("too many frames in flight");
endmodule

bind ball_hypothesis_tracker_top bht_checker u_bht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_obs.valid),
    .i_in_ready  (i_obs.ready),
    .i_in_last   (i_obs.frame_last),
    .i_out_valid (o_est.valid),
    .i_out_ready (o_est.ready),
    .i_out_cert  (o_est.est_certainty)
);
`default_nettype wire

// File: test/tb_bht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bht_pkg
// Circle-table predictor and estimate scoreboard for the ball tracker bench.
// ----------------------------------------------------------------------------
package tb_bht_pkg;
    import bht_pkg::*;

    localparam int N_CIRCLES = 64;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] cert;
        logic        ovf;
    } t_est;

    class bht_tracker_sb;
        logic [15:0] decay;
        logic [14:0] radius;
        logic [15:0] thr;
        bit          cv[N_CIRCLES];
        logic [15:0] cx[N_CIRCLES];
        logic [15:0] cy[N_CIRCLES];
        logic [16:0] cc[N_CIRCLES];
        bit          seen;
        logic [15:0] bc;
        logic [15:0] bx;
        logic [15:0] by;
        t_est        pending[$];
        int          errors;

        function void clear();
            decay = DECAY_RST;
            radius = RADIUS_RST;
            thr = THR_RST;
            foreach (cv[i]) begin
                cv[i] = 0;
                cx[i] = '0;
                cy[i] = '0;
                cc[i] = '0;
            end
            cv[0] = 1;
            cc[0] = {1'b0, THR_RST};
            seen = 0;
            bc = '0;
            bx = '0;
            by = '0;
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] d);
            case (idx)
                CFG_DECAY: decay = d;
                CFG_RADIUS: radius = d[14:0];
                CFG_THR: thr = d;
                default: ;
            endcase
        endfunction

        function logic [16:0] qmul(logic [16:0] a, logic [16:0] b);
            logic [33:0] p;
            p = a * b;
            return p[32:16];
        endfunction

        function bit rank(logic [16:0] ca, logic [15:0] xa, logic [15:0] ya,
                          logic [16:0] cb, logic [15:0] xb, logic [15:0] yb);
            if (ca != cb) return ca > cb;
            if (xa != xb) return $signed(xa) > $signed(xb);
            return $signed(ya) > $signed(yb);
        endfunction

        function void note_word(bit pres, logic [15:0] c, logic [15:0] x, logic [15:0] y,
                                bit last);
            logic [16:0] miss;
            logic [16:0] keep;
            longint      dx;
            longint      dy;
            longint      r2;
            logic [16:0] nc;
            int          slot;
            int          weakest;
            int          pick;
            t_est        e;
            if (pres && (!seen || rank({1'b0, c}, x, y, {1'b0, bc}, bx, by))) begin
                seen = 1;
                bc = c;
                bx = x;
                by = y;
            end
            if (!last) return;
            e.ovf = 0;
            keep = 17'h10000 - decay;
            if (seen) begin
                miss = keep;
                r2 = longint'(radius) * longint'(radius);
                for (int i = 0; i < N_CIRCLES; i++) begin
                    if (!cv[i]) continue;
                    dx = longint'($signed(bx)) - longint'($signed(cx[i]));
                    dy = longint'($signed(by)) - longint'($signed(cy[i]));
                    if (dx * dx + dy * dy < r2) begin
                        miss = qmul(miss, 17'h10000 - cc[i]);
                        cv[i] = 0;
                    end
                end
                for (int i = 0; i < N_CIRCLES; i++) begin
                    if (!cv[i]) continue;
                    cc[i] = qmul(cc[i], keep);
                    if (cc[i] < thr) cv[i] = 0;
                end
                nc = 17'h10000 - miss;
                if (nc > 17'hFFFF) nc = 17'hFFFF;
                slot = -1;
                weakest = 0;
                for (int i = 0; i < N_CIRCLES; i++) begin
                    if (!cv[i]) begin
                        slot = i;
                        break;
                    end
                    if (cc[i] < cc[weakest]) weakest = i;
                end
                if (slot < 0) begin
                    slot = weakest;
                    e.ovf = 1;
                end
                cv[slot] = 1;
                cx[slot] = bx;
                cy[slot] = by;
                cc[slot] = nc;
            end else begin
                for (int i = 0; i < N_CIRCLES; i++)
                    if (cv[i]) cc[i] = qmul(cc[i], keep);
            end
            seen = 0;
            bc = '0;
            bx = '0;
            by = '0;
            pick = -1;
            for (int i = 0; i < N_CIRCLES; i++) begin
                if (!cv[i]) continue;
                if (pick < 0 || rank(cc[i], cx[i], cy[i], cc[pick], cx[pick], cy[pick]))
                    pick = i;
            end
            e.x = pick >= 0 ? cx[pick] : '0;
            e.y = pick >= 0 ? cy[pick] : '0;
            e.cert = pick >= 0 ? cc[pick][15:0] : '0;
            pending.push_back(e);
        endfunction

        function void check_est(logic [15:0] x, logic [15:0] y, logic [15:0] c, logic o);
            t_est e;
            if (pending.size() == 0) begin
                $error("estimate with none pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (x !== e.x) begin
                $error("est_x exp %h got %h", e.x, x);
                errors++;
            end
            if (y !== e.y) begin
                $error("est_y exp %h got %h", e.y, y);
                errors++;
            end
            if (c !== e.cert) begin
                $error("est_certainty exp %h got %h", e.cert, c);
                errors++;
            end
            if (o !== e.ovf) begin
                $error("table_overflow exp %b got %b", e.ovf, o);
                errors++;
            end
        endfunction
    endclass
endpackage

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Ball tracker bench: directed and random frames with random gaps on both
// sides, register sweeps between phases, estimates checked by a scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
    import bht_pkg::*;
    import tb_bht_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   cycles;
    bit   calm;
    bit   hold_rx;
    bht_tracker_sb sb;

    bht_obs_if obs();
    bht_cfg_if cfg();
    bht_est_if est();

    ball_hypothesis_tracker_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_obs(obs.sink), .i_cfg(cfg.sink),
        .o_est(est.source)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        obs.valid = 0;
        obs.obs_present = 0;
        obs.obs_confidence = '0;
        obs.obs_x = '0;
        obs.obs_y = '0;
        obs.frame_last = 0;
        cfg.valid = 0;
        cfg.index = CFG_DECAY;
        cfg.data = '0;
        est.ready = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && est.valid && est.ready)
            sb.check_est(est.est_x, est.est_y, est.est_certainty, est.table_overflow);
    end

    // receiver stalls in bursts
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (calm || hold_rx || $urandom_range(0, 3) != 0) begin
                est.ready <= 1;
            end else begin
                n = $urandom_range(1, 6);
                est.ready <= 0;
                repeat (n) @(posedge i_clk);
                est.ready <= 1;
            end
        end
    end

    task automatic send_word(bit pres, logic [15:0] c, logic [15:0] x, logic [15:0] y,
                             bit last);
        if (!calm && $urandom_range(0, 4) == 0) begin
            obs.valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        obs.valid <= 1;
        obs.obs_present <= pres;
        obs.obs_confidence <= c;
        obs.obs_x <= x;
        obs.obs_y <= y;
        obs.frame_last <= last;
        do @(posedge i_clk); while (!obs.ready);
        sb.note_word(pres, c, x, y, last);
    endtask

    task automatic drain();
        obs.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] d);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= d;
        do @(posedge i_clk); while (!cfg.ready);
        sb.write_reg(idx, d);
        cfg.valid <= 0;
        @(posedge i_clk);
    endtask

    // clustered positions keep merges common
    task automatic rand_frame(int spread);
        int k;
        k = $urandom_range(0, 4);
        for (int i = 0; i <= k; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_word(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                          16'($urandom), i == k);
            else
                send_word($urandom_range(0, 5) != 0, 16'($urandom),
                          16'($signed($urandom_range(0, 2 * spread)) - spread),
                          16'($signed($urandom_range(0, 2 * spread)) - spread), i == k);
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        calm = 0;
        hold_rx = 0;
        i_rst_n = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_word(0, 0, 0, 0, 1);
        send_word(1, 16'hFFFF, 16'h7FFF, 16'h8000, 0);
        send_word(1, 16'hFFFF, 16'h7FFF, 16'h7FFF, 0);
        send_word(1, 16'hFFFF, 16'h7FFF, 16'h7FFF, 0);
        send_word(0, 16'hFFFF, 16'h1234, 16'h4321, 0);
        send_word(1, 16'h0000, 16'h8000, 16'h8000, 1);
        send_word(1, 16'h0000, 16'h8000, 16'h8000, 1);
        send_word(1, 16'h8000, 16'h0000, 16'h0000, 1);
        send_word(1, 16'h8000, 16'h0010, 16'h0010, 1);
        send_word(0, 0, 0, 0, 0);
        send_word(0, 0, 0, 0, 1);
        drain();
        write_reg(CFG_DECAY, 16'h0000);
        write_reg(CFG_RADIUS, 16'h0000);
        write_reg(CFG_THR, 16'h0000);
        for (int i = 0; i < 70; i++)
            send_word(1, 16'($urandom), 16'(i * 64), 16'(-i * 64), 1);
        send_word(1, 16'hFFFF, 16'h0000, 16'h0000, 1);
        drain();
        write_reg(CFG_DECAY, 16'hFFFF);
        write_reg(CFG_RADIUS, 16'h7FFF);
        write_reg(CFG_THR, 16'hFFFF);
        send_word(1, 16'hFFFF, 16'h8000, 16'h8000, 1);
        send_word(1, 16'h0001, 16'h7FFF, 16'h7FFF, 1);
        send_word(0, 0, 0, 0, 1);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_DECAY, ph == 5 ? DECAY_RST : 16'($urandom_range(0, 30000)));
            write_reg(CFG_RADIUS, ph == 5 ? 16'(RADIUS_RST) : 16'($urandom_range(0, 4000)));
            write_reg(CFG_THR, ph == 5 ? THR_RST : 16'($urandom_range(0, 8000)));
            if (ph == 5) calm = 1;
            for (int f = 0; f < 60; f++) rand_frame(ph == 2 ? 32767 : 3000);
            if (ph == 3) begin
                obs.valid <= 0;
                hold_rx = 1;
                @(posedge i_clk);
                while (sb.pending.size() != 0) @(posedge i_clk);
                hold_rx = 0;
            end
            drain();
        end
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/core/bht_pkg.sv
rtl/core/bht_if.sv
rtl/core/bht_ram.sv
rtl/core/bht_front.sv
rtl/core/bht_fifo.sv
rtl/core/bht_back.sv
rtl/core/ball_hypothesis_tracker_top.sv
rtl/core/bht_checker.sv
test/tb_bht_pkg.sv
test/tb_top.sv
